### src/dsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal square root - shared package
// Controller states, datapath command group and fixed field widths.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int unsigned ROOT_W = 22;
  localparam int unsigned DP_W   = 3;

  localparam logic [DP_W-1:0]   DP_RESET = 3'd2;
  localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ROOT,
    ST_DONE
  } dsr_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture a new radicand, clear root and remainder
    logic scale;   // scaled radicand times ten
    logic step;    // one root bit of the binary recurrence
    logic finish;  // register the result and raise the strobe
  } dsr_cmd_t;

endpackage

### src/dsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal square root - controller
// Sequences load, 2d scaling steps, the root recurrence and the result write.
// ----------------------------------------------------------------------------
module dsr_ctrl #(
  parameter int unsigned MAX_DECIMALS = 4,
  parameter int unsigned ROOT_BITS    = 28
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic [dsr_pkg::DP_W-1:0] decimals_i,
  output logic                     busy,
  output dsr_pkg::dsr_cmd_t        cmd_o
);
  import dsr_pkg::*;

  localparam int unsigned MAX_CNT = (2 * MAX_DECIMALS > ROOT_BITS) ?
                                    2 * MAX_DECIMALS : ROOT_BITS;
  localparam int unsigned CNT_W   = $clog2(MAX_CNT + 1);

  dsr_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DP_W-1:0]  dec_eff;
  logic [CNT_W-1:0] scale_cnt;

  // places above the maximum count as the maximum
  assign dec_eff   = (decimals_i > DP_W'(MAX_DECIMALS)) ? DP_W'(MAX_DECIMALS) : decimals_i;
  assign scale_cnt = CNT_W'({dec_eff, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (scale_cnt == '0) begin
            state_d = ST_ROOT;
            cnt_d   = CNT_W'(ROOT_BITS);
          end else begin
            state_d = ST_SCALE;
            cnt_d   = scale_cnt;
          end
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        cnt_d       = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_ROOT;
          cnt_d   = CNT_W'(ROOT_BITS);
        end
      end
      ST_ROOT: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

### src/dsr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal square root - datapath
// Radicand scaling by ten per cycle, restoring root recurrence, result regs.
// ----------------------------------------------------------------------------
module dsr_datapath #(
  parameter int unsigned RADICAND_WIDTH = 16,
  parameter int unsigned SCALED_W       = 56,
  parameter int unsigned ROOT_BITS      = 28
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dsr_pkg::dsr_cmd_t          cmd_i,
  input  logic [RADICAND_WIDTH-1:0]  radicand_i,
  output logic [dsr_pkg::ROOT_W-1:0] root_scaled_o,
  output logic                       exact_o,
  output logic                       done_o
);
  import dsr_pkg::*;

  localparam int unsigned REM_W = ROOT_BITS + 2;
  localparam int unsigned CMP_W = (ROOT_BITS > ROOT_W) ? ROOT_BITS : ROOT_W;

  logic [SCALED_W-1:0]  scaled_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [REM_W-1:0]     rem_q;
  logic [REM_W-1:0]     rem_shift;
  logic [REM_W:0]       trial;
  logic                 trial_neg;
  logic [CMP_W-1:0]     root_ext;
  logic                 sat;
  logic [ROOT_W-1:0]    root_out_q;
  logic                 exact_q;
  logic                 done_q;

  // bring down the next radicand bit pair and try root*4 + 1
  assign rem_shift = {rem_q[REM_W-3:0], scaled_q[SCALED_W-1 -: 2]};
  assign trial     = {1'b0, rem_shift} - {1'b0, root_q, 2'b01};
  assign trial_neg = trial[REM_W];

  assign root_ext = CMP_W'(root_q);
  assign sat      = root_ext > CMP_W'(ROOT_MAX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      scaled_q <= SCALED_W'(radicand_i);
      root_q   <= '0;
      rem_q    <= '0;
    end else if (cmd_i.scale) begin
      // x*10 = x*8 + x*2
      scaled_q <= (scaled_q << 3) + (scaled_q << 1);
    end else if (cmd_i.step) begin
      scaled_q <= scaled_q << 2;
      root_q   <= {root_q[ROOT_BITS-2:0], ~trial_neg};
      rem_q    <= trial_neg ? rem_shift : trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      root_out_q <= sat ? ROOT_MAX : ROOT_W'(root_q);
      exact_q    <= !sat && (rem_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign root_scaled_o = root_out_q;
  assign exact_o       = exact_q;
  assign done_o        = done_q;

endmodule

### src/decimal_square_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal square root
// root_scaled = floor(sqrt(radicand * 10^(2d))), exact when nothing remains.
// ----------------------------------------------------------------------------
//  channel   ports                                 handshake
//  request   start, radicand_i                     taken when start && !busy
//  result    done_o, root_scaled_o, exact_o        one-cycle strobe, no stall
//  config    cfg_we_i, cfg_data_i                  written when cfg_we_i
//
//  A request runs the load, 2*d scaling steps, ROOT_BITS root steps and the
//  result write; a new request is taken only once busy falls again. d is the clamped
//  decimal_places, ROOT_BITS is half the scaled radicand width (22 by default).
//  Scaling is one multiply-by-ten per cycle, the root one bit per cycle. Reset
//  clears the controller and sets decimal_places to 2.
// ----------------------------------------------------------------------------
module decimal_square_root #(
  parameter int unsigned RADICAND_WIDTH = 16,
  parameter int unsigned MAX_DECIMALS   = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [RADICAND_WIDTH-1:0]  radicand_i,
  input  logic                       cfg_we_i,
  input  logic [dsr_pkg::DP_W-1:0]   cfg_data_i,
  output logic                       done_o,
  output logic [dsr_pkg::ROOT_W-1:0] root_scaled_o,
  output logic                       exact_o
);
  import dsr_pkg::*;

  localparam longint unsigned SCALE_MAX = 64'd10 ** (2 * MAX_DECIMALS);
  localparam int unsigned     SCALE_W   = $clog2(SCALE_MAX);
  localparam int unsigned     RAW_W     = RADICAND_WIDTH + SCALE_W;
  localparam int unsigned     SCALED_W  = RAW_W + (RAW_W % 2);
  localparam int unsigned     ROOT_BITS = SCALED_W / 2;

  logic [DP_W-1:0] decimals_q;
  dsr_cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decimals_q <= DP_RESET;
    end else if (cfg_we_i) begin
      decimals_q <= cfg_data_i;
    end
  end

  dsr_ctrl #(
    .MAX_DECIMALS (MAX_DECIMALS),
    .ROOT_BITS    (ROOT_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .decimals_i (decimals_q),
    .busy       (busy),
    .cmd_o      (cmd)
  );

  dsr_datapath #(
    .RADICAND_WIDTH (RADICAND_WIDTH),
    .SCALED_W       (SCALED_W),
    .ROOT_BITS      (ROOT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .radicand_i    (radicand_i),
    .root_scaled_o (root_scaled_o),
    .exact_o       (exact_o),
    .done_o        (done_o)
  );

endmodule
